[src/ctr_pkg.sv]
// ============================================================================
// ctr_pkg - shared types and codes for the capture timestamp ring
// Transaction payload structs, command, status and register index codes.
// ============================================================================
package ctr_pkg;

    localparam int TS_SHIFT = 16;

    // command codes
    localparam logic [1:0] CMD_OVERFLOW = 2'd0;
    localparam logic [1:0] CMD_CAPTURE  = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;

    // read status codes
    localparam logic [1:0] STS_EMPTY = 2'd0;
    localparam logic [1:0] STS_DATA  = 2'd1;
    localparam logic [1:0] STS_LOST  = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHANNEL_ENABLE = 1'b0;
    localparam logic CFG_LATE_THRESHOLD = 1'b1;

    localparam logic [15:0] LATE_THRESHOLD_RST = 16'hE000;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  channel;
        logic [15:0] capture_value;
        logic        same_pass;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sample_value;
    } t_out_item;

endpackage

[src/capture_timestamp_ring.sv]
// ============================================================================
// capture_timestamp_ring - multi-channel input-capture timestamp store
// Extends 16-bit captures with an overflow count and queues them per channel.
// ============================================================================
// Overflow and capture transactions can be accepted back to back. A read
// transaction holds off further input until its sample is out: the
// ring memory has a registered read port, so the sample leaves the memory at
// the accepting edge and reaches the output register the cycle after, and
// the next transaction is accepted once it has moved into the output
// register. The output register holds a result until it is taken; while a
// result waits there unaccepted, no transaction of any kind is accepted, and
// a new transaction can be accepted on the cycle the old result leaves.
// Each channel owns RING_DEPTH entries of one shared sample memory. Pointers
// are 32-bit and wrap; the ring slot is the pointer modulo RING_DEPTH, which
// is carried alongside each pointer so no divider is needed, including the
// case where RING_DEPTH is not a power of two. When more than RING_DEPTH
// samples are pending, a read skips to the oldest of the newest RING_DEPTH-1
// and reports status 2 (data after lost samples). Reads of an empty ring or
// of a channel beyond CHANNELS return status 0 with a zero timestamp.
// ============================================================================
module capture_timestamp_ring
    import ctr_pkg::*;
#(
    parameter int RING_DEPTH = 64,
    parameter int CHANNELS   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // configuration write port
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input transactions
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    // result transactions
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int SW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * RING_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // 2^32 mod RING_DEPTH: slot offset seen when a pointer wraps below zero
    localparam longint unsigned K_WRAP = 64'h1_0000_0000 % RING_DEPTH;
    localparam logic [SW:0]  K_SLOT    = (SW+1)'(K_WRAP);
    localparam logic [SW:0]  DEPTH_W   = (SW+1)'(RING_DEPTH);
    localparam logic [SW:0]  LAST_SLOT = (SW+1)'(RING_DEPTH - 1);
    localparam logic [31:0]  RD32      = 32'(RING_DEPTH);
    localparam logic [31:0]  RDM1      = 32'(RING_DEPTH - 1);
    localparam logic [AW-1:0] ROW_BASE = AW'(RING_DEPTH);

    // slot of (ptr + 1) given the slot of ptr
    function automatic logic [SW-1:0] f_slot_inc(input logic [31:0] ptr,
                                                 input logic [SW-1:0] slot);
        if (ptr == '1) begin
            return '0;
        end else if ({1'b0, slot} == LAST_SLOT) begin
            return '0;
        end else begin
            return slot + SW'(1);
        end
    endfunction

    // configuration
    logic [7:0]  r_channel_enable;
    logic [15:0] r_late_threshold;

    // state
    logic [15:0]   r_overflow_count;
    logic [31:0]   r_wr_ptr  [CHANNELS];
    logic [SW-1:0] r_wr_slot [CHANNELS];
    logic [31:0]   r_rd_ptr  [CHANNELS];
    logic [SW-1:0] r_rd_slot [CHANNELS];
    logic [31:0]   r_mem     [DEPTH];
    logic [31:0]   r_rd_data;

    // pipeline control
    logic      r_pend;
    logic [1:0] r_pend_status;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic          accept;
    logic          ch_ok;
    logic [CW-1:0] chi;
    logic [31:0]   w_ptr, rd_ptr, diff, eff_ptr;
    logic [SW-1:0] w_slot, rd_slot, eff_slot, jump_slot;
    logic [SW:0]   wrap_sum;
    logic          lost;
    logic [15:0]   ts_hi;
    logic          do_capture, do_read, rd_nonempty;
    logic [SW-1:0] access_slot;
    logic [AW-1:0] mem_addr;
    logic [31:0]   n_rd_ptr;
    logic [SW-1:0] n_rd_slot;
    logic [1:0]    n_status;

    assign o_in_ready  = !r_pend && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign chi   = i_in_data.channel[CW-1:0];
    assign ch_ok = 32'(i_in_data.channel) < 32'(CHANNELS);

    always_comb begin
        w_ptr   = r_wr_ptr[chi];
        w_slot  = r_wr_slot[chi];
        rd_ptr  = r_rd_ptr[chi];
        rd_slot = r_rd_slot[chi];
        diff    = w_ptr - rd_ptr;
        lost    = diff > RD32;

        // slot of (w - RING_DEPTH + 1) modulo 2^32
        wrap_sum = K_SLOT + {1'b0, w_ptr[SW-1:0]} + (SW+1)'(1);
        if (w_ptr >= RDM1) begin
            jump_slot = ({1'b0, w_slot} == LAST_SLOT) ? '0 : w_slot + SW'(1);
        end else if (wrap_sum >= DEPTH_W) begin
            jump_slot = SW'(wrap_sum - DEPTH_W);
        end else begin
            jump_slot = wrap_sum[SW-1:0];
        end

        eff_ptr   = lost ? (w_ptr - RDM1) : rd_ptr;
        eff_slot  = lost ? jump_slot : rd_slot;
        n_rd_ptr  = eff_ptr + 32'd1;
        n_rd_slot = f_slot_inc(eff_ptr, eff_slot);

        ts_hi = r_overflow_count;
        if (i_in_data.capture_value > r_late_threshold && i_in_data.same_pass) begin
            ts_hi = r_overflow_count - 16'd1;
        end

        do_capture  = accept && i_in_data.command == CMD_CAPTURE && ch_ok
                      && r_channel_enable[i_in_data.channel];
        do_read     = accept && i_in_data.command == CMD_READ;
        rd_nonempty = ch_ok && (diff != 32'd0);

        if (!rd_nonempty) begin
            n_status = STS_EMPTY;
        end else if (lost) begin
            n_status = STS_LOST;
        end else begin
            n_status = STS_DATA;
        end

        access_slot = (i_in_data.command == CMD_CAPTURE) ? w_slot : eff_slot;
        mem_addr    = AW'(chi) * ROW_BASE + AW'(access_slot);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_enable <= '0;
            r_late_threshold <= LATE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_ENABLE: r_channel_enable <= i_cfg_data[7:0];
                CFG_LATE_THRESHOLD: r_late_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // overflow count and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow_count <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wr_ptr[c]  <= '0;
                r_wr_slot[c] <= '0;
                r_rd_ptr[c]  <= '0;
                r_rd_slot[c] <= '0;
            end
        end else begin
            if (accept && i_in_data.command == CMD_OVERFLOW) begin
                r_overflow_count <= r_overflow_count + 16'd1;
            end
            if (do_capture) begin
                r_wr_ptr[chi]  <= w_ptr + 32'd1;
                r_wr_slot[chi] <= f_slot_inc(w_ptr, w_slot);
            end
            if (do_read && rd_nonempty) begin
                r_rd_ptr[chi]  <= n_rd_ptr;
                r_rd_slot[chi] <= n_rd_slot;
            end
        end
    end

    // sample memory with a registered read port
    always_ff @(posedge i_clk) begin
        if (do_capture) begin
            r_mem[mem_addr] <= {ts_hi, i_in_data.capture_value};
        end
        if (do_read) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // read pending stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= do_read;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_pend_status <= n_status;
        end
        if (r_pend) begin
            r_out_data.status       <= r_pend_status;
            r_out_data.sample_value <= (r_pend_status == STS_EMPTY) ? 32'd0 : r_rd_data;
        end
    end

endmodule

[tb/tb_capture_timestamp_ring.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_capture_timestamp_ring - self-checking bench for the timestamp ring
// Drives overflow, capture and read transactions with bursty input pacing
// and a stalling result sink. A scoreboard class tracks the overflow count,
// the per-channel rings and pointers, predicts each read result and checks
// the results in order. Runs through several register settings, overruns,
// drains and late captures that pull the upper half below zero.
// ============================================================================
module tb_capture_timestamp_ring
    import ctr_pkg::*;
;
    localparam int RING_DEPTH = 64;
    localparam int CHANNELS   = 8;
    // cycles with no transaction on either side before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    // command code with no function
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_CHANNEL_ENABLE;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    t_out_item   o_out_data;

    // result sink stall patterns
    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_CHOKED} t_sink_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the block's state, predicts read results at accept
    // time and checks results against the oldest prediction.
    // ------------------------------------------------------------------------
    class ring_scoreboard;
        logic [7:0]  chan_enable;
        logic [15:0] late_thr;
        logic [15:0] ovf_count;
        logic [31:0] ring_mem [CHANNELS*RING_DEPTH];
        logic [31:0] wr_ptr [CHANNELS];
        logic [31:0] rd_ptr [CHANNELS];
        t_out_item   expected_samples [$];
        int          errors;

        function new();
            chan_enable = '0;
            late_thr    = LATE_THRESHOLD_RST;
            ovf_count   = '0;
            errors      = 0;
            foreach (ring_mem[i]) ring_mem[i] = '0;
            foreach (wr_ptr[i]) begin
                wr_ptr[i] = '0;
                rd_ptr[i] = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [15:0] data);
            if (idx == CFG_CHANNEL_ENABLE) begin
                chan_enable = data[7:0];
            end else begin
                late_thr = data;
            end
        endfunction

        function int slot(int ch, logic [31:0] ptr);
            return ch * RING_DEPTH + int'(ptr % 32'(RING_DEPTH));
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void note_transaction(t_in_item it);
            logic [15:0] hi;
            logic [31:0] r;
            t_out_item   res;
            int          ch;
            ch = int'(it.channel);
            case (it.command)
                CMD_OVERFLOW: begin
                    ovf_count = ovf_count + 16'd1;
                end
                CMD_CAPTURE: begin
                    if (ch < CHANNELS && chan_enable[ch]) begin
                        hi = ovf_count;
                        // late capture with a same-pass overflow belongs to
                        // the window before the overflow
                        if (it.capture_value > late_thr && it.same_pass) hi = hi - 16'd1;
                        ring_mem[slot(ch, wr_ptr[ch])] = {hi, it.capture_value};
                        wr_ptr[ch] = wr_ptr[ch] + 32'd1;
                    end
                end
                CMD_READ: begin
                    res = '{status: STS_EMPTY, sample_value: '0};
                    if (ch < CHANNELS && wr_ptr[ch] != rd_ptr[ch]) begin
                        r = rd_ptr[ch];
                        res.status = STS_DATA;
                        // overrun: keep only the newest RING_DEPTH-1, starting with this one
                        if (wr_ptr[ch] - r > 32'(RING_DEPTH)) begin
                            res.status = STS_LOST;
                            r = wr_ptr[ch] - 32'(RING_DEPTH) + 32'd1;
                        end
                        res.sample_value = ring_mem[slot(ch, r)];
                        rd_ptr[ch] = r + 32'd1;
                    end
                    expected_samples.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_sample(t_out_item got);
            t_out_item exp;
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d sample %h",
                         $time, got.status, got.sample_value);
                errors++;
                return;
            end
            exp = expected_samples.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp.status, got.status);
                errors++;
            end
            if (got.sample_value !== exp.sample_value) begin
                $display("%0t: sample mismatch, expected %h, actual %h",
                         $time, exp.sample_value, got.sample_value);
                errors++;
            end
        endfunction
    endclass

    ring_scoreboard sb = new();
    int burst_left = 16;

    capture_timestamp_ring #(
        .RING_DEPTH (RING_DEPTH),
        .CHANNELS   (CHANNELS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_in_item item_of(logic [1:0] cmd, logic [2:0] ch,
                                         logic [15:0] cap, logic sp);
        t_in_item it;
        it.command       = cmd;
        it.channel       = ch;
        it.capture_value = cap;
        it.same_pass     = sp;
        return it;
    endfunction

    // Random transaction: mostly captures and reads, half of them on a hot
    // channel so its ring overruns or drains; capture values cluster at the
    // threshold edges and the 16-bit extremes.
    function automatic t_in_item rand_item(int cap_pct, int read_pct, logic [2:0] hot);
        t_in_item it;
        int       r;
        r = int'($urandom_range(99));
        if (r < 15)                           it.command = CMD_OVERFLOW;
        else if (r < 15 + cap_pct)            it.command = CMD_CAPTURE;
        else if (r < 15 + cap_pct + read_pct) it.command = CMD_READ;
        else                                  it.command = CMD_UNUSED;
        it.channel = $urandom_range(1) ? hot : 3'($urandom_range(7));
        case ($urandom_range(7))
            0:       it.capture_value = sb.late_thr;
            1:       it.capture_value = sb.late_thr + 16'd1;
            2:       it.capture_value = 16'h0000;
            3:       it.capture_value = 16'hFFFF;
            default: it.capture_value = 16'($urandom);
        endcase
        it.same_pass = 1'($urandom_range(1));
        return it;
    endfunction

    // Present one transaction, hold it until accepted, then pace the next
    // burst. Entered and left just after a rising edge.
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transaction(it);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(7) == 0) ? 200 : int'($urandom_range(1, 32));
        end
    endtask

    // Stop sending, wait for every predicted result, then let in-flight
    // overflow/capture work retire before any register write.
    task automatic settle();
        if (i_in_valid) i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // result sink: checks each accepted result and stalls on its own pattern
    initial begin : result_sink
        t_sink_mode mode;
        int         left;
        mode = SINK_OPEN;
        left = 50;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_sample(o_out_data);
            if (left == 0) begin
                mode = t_sink_mode'($urandom_range(2));
                left = $urandom_range(20, 200);
            end else begin
                left--;
            end
            case (mode)
                SINK_OPEN:   i_out_ready <= 1'b1;
                SINK_RANDOM: i_out_ready <= 1'($urandom_range(1));
                default:     i_out_ready <= ($urandom_range(4) == 0);
            endcase
        end
    end

    // watchdog: ends the run once its idle count reaches IDLE_LIMIT with no transaction moving
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb_capture_timestamp_ring NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [2:0]  hot;
        logic [7:0]  en;
        logic [15:0] thr;
        int          cap_pct;
        int          read_pct;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- reset settings: every channel disabled ---
        send_item(item_of(CMD_CAPTURE, 3'd0, 16'hFFFF, 1'b1));   // dropped
        send_item(item_of(CMD_READ, 3'd0, 16'h0000, 1'b0));      // empty ring
        send_item(item_of(CMD_UNUSED, 3'($urandom), 16'($urandom), 1'($urandom)));
        settle();

        // upper data bits of the enable write must be ignored
        write_cfg(CFG_CHANNEL_ENABLE, {8'hA5, 8'hFF});
        write_cfg(CFG_LATE_THRESHOLD, 16'hE000);

        // late capture with overflow count zero wraps the upper half to FFFF
        send_item(item_of(CMD_CAPTURE, 3'd0, 16'h0000, 1'b0));
        send_item(item_of(CMD_CAPTURE, 3'd0, 16'hFFFF, 1'b1));
        send_item(item_of(CMD_OVERFLOW, 3'($urandom), 16'($urandom), 1'($urandom)));
        // exactly at the threshold is not late; one above is
        send_item(item_of(CMD_CAPTURE, 3'd1, 16'hE000, 1'b1));
        send_item(item_of(CMD_CAPTURE, 3'd1, 16'hE001, 1'b1));
        send_item(item_of(CMD_CAPTURE, 3'd1, 16'hE001, 1'b0));
        repeat (3) send_item(item_of(CMD_READ, 3'd0, 16'($urandom), 1'($urandom)));
        repeat (4) send_item(item_of(CMD_READ, 3'd1, 16'($urandom), 1'($urandom)));
        send_item(item_of(CMD_CAPTURE, 3'd7, 16'h1234, 1'b0));
        send_item(item_of(CMD_CAPTURE, 3'd7, 16'h5678, 1'b1));
        send_item(item_of(CMD_READ, 3'd7, 16'h0000, 1'b0));
        settle();

        // disabled channel: captures dropped, reads still drain the ring
        write_cfg(CFG_CHANNEL_ENABLE, 16'h007F);
        send_item(item_of(CMD_CAPTURE, 3'd7, 16'hABCD, 1'b0));
        send_item(item_of(CMD_READ, 3'd7, 16'h0000, 1'b0));
        send_item(item_of(CMD_READ, 3'd7, 16'h0000, 1'b0));
        settle();

        // --- random phases, mixing capture-heavy, balanced and read-heavy traffic ---
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin en = 8'hFF;            thr = 16'hE000;     cap_pct = 65; read_pct = 15; end
                1: begin en = 8'($urandom);     thr = 16'($urandom); cap_pct = 40; read_pct = 40; end
                2: begin en = 8'hFF;            thr = 16'h0000;     cap_pct = 65; read_pct = 15; end
                3: begin en = 8'h00;            thr = 16'hFFFF;     cap_pct = 20; read_pct = 60; end
                4: begin en = 8'($urandom);     thr = 16'hFFFF;     cap_pct = 60; read_pct = 20; end
                default: begin en = 8'hFF;      thr = 16'($urandom); cap_pct = 15; read_pct = 65; end
            endcase
            write_cfg(CFG_CHANNEL_ENABLE, {8'($urandom), en});
            write_cfg(CFG_LATE_THRESHOLD, thr);
            hot = 3'($urandom_range(7));
            repeat (200) send_item(rand_item(cap_pct, read_pct, hot));
            settle();
        end

        // --- drain channel 2, then captures around one overflow ---
        write_cfg(CFG_CHANNEL_ENABLE, 16'h00FF);
        write_cfg(CFG_LATE_THRESHOLD, 16'hE000);
        repeat (RING_DEPTH) send_item(item_of(CMD_READ, 3'd2, 16'($urandom), 1'($urandom)));
        send_item(item_of(CMD_CAPTURE, 3'd2, 16'h0100, 1'b0));   // current window
        send_item(item_of(CMD_OVERFLOW, 3'd2, 16'h0000, 1'b0));
        send_item(item_of(CMD_CAPTURE, 3'd2, 16'hF000, 1'b1));   // late: previous window
        send_item(item_of(CMD_CAPTURE, 3'd2, 16'hF000, 1'b0));
        repeat (4) send_item(item_of(CMD_READ, 3'd2, 16'h0000, 1'b0));
        settle();
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_capture_timestamp_ring OK");
        end else begin
            $display("tb_capture_timestamp_ring NOT OK");
        end
        $finish;
    end

endmodule
